@@ hw/rtl/pstb_pkg.sv @@
// package for the per-source token bucket limiter
// shared constants, command/status structs, fnv step function; no dependencies
`default_nettype none
package pstb_pkg;
    localparam int TableEntriesDefault = 1024;
    localparam int ProbeLimitDefault   = 16;
    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] FNV_PRIME_LOW = 64'h1B3;
    localparam logic [7:0]  FAM_V4    = 8'd2;
    localparam logic [7:0]  FAM_V6    = 8'd10;
    localparam logic [47:0] GAIN_SAT  = 48'h2_0000_0000;

    localparam logic [1:0] REG_REFILL = 2'd0;
    localparam logic [1:0] REG_BURST  = 2'd1;
    localparam logic [1:0] REG_IDLE   = 2'd2;
    localparam logic [1:0] REG_PORT   = 2'd3;

    localparam logic [1:0] OUT_MATCH = 2'd0;
    localparam logic [1:0] OUT_FREE  = 2'd1;
    localparam logic [1:0] OUT_STALE = 2'd2;
    localparam logic [1:0] OUT_NONE  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clr;       // clear one table entry
        logic load;      // capture key and start hash
        logic hash_step; // one fnv byte
        logic rd;        // issue slot read at probe index
        logic eval;      // examine registered slot data
        logic mul;       // refill products
        logic upd;       // write matched slot
        logic ins;       // write new slot
        logic next;      // advance probe index
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic slot_free;
        logic slot_match;
        logic probe_last;
        logic have_slot;
        logic clr_done;
    } t_stat;

    // one fnv-1a byte step; the prime is 2^40 + 0x1b3, so a shift plus a narrow multiply
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return {x[23:0], 40'd0} + (x * FNV_PRIME_LOW);
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/pstb_datapath.sv @@
// datapath: key build, fnv hash, slot table memory, probe and bucket arithmetic
// depends on pstb_pkg
`default_nettype none
module pstb_datapath import pstb_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int PROBE_LIMIT   = ProbeLimitDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [63:0] i_now_ns,
    input  wire logic [7:0]  i_addr_family,
    input  wire logic [15:0] i_src_port,
    input  wire logic [63:0] i_address_high,
    input  wire logic [63:0] i_address_low,
    input  wire logic [31:0] i_refill,
    input  wire logic [15:0] i_burst,
    input  wire logic [47:0] i_idle,
    input  wire logic        i_use_port,
    output logic             o_allow,
    output logic [1:0]       o_outcome
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(PROBE_LIMIT + 1);

    typedef struct packed {
        logic        vld;
        logic [7:0]  fam;
        logic [15:0] port;
        logic [63:0] ah;
        logic [63:0] al;
        logic [31:0] tok;
        logic [63:0] rt;
        logic [63:0] st;
    } t_slot;

    // key registers
    logic [7:0]  r_fam;
    logic [15:0] r_port;
    logic [63:0] r_ah, r_al, r_now;
    logic [159:0] r_key;
    logic [4:0]  r_bcnt;
    logic [63:0] r_hash;
    logic [63:0] hash_nx;
    logic [7:0]  fam_c;
    logic [63:0] ah_c, al_c;
    logic [15:0] port_c;

    always_comb begin
        fam_c = 8'd0; ah_c = 64'd0; al_c = 64'd0;
        if (i_addr_family == FAM_V4) begin
            fam_c = FAM_V4; ah_c = {i_address_high[63:32], 32'd0};
        end else if (i_addr_family == FAM_V6) begin
            fam_c = FAM_V6; ah_c = i_address_high; al_c = i_address_low;
        end
        port_c = (i_use_port && fam_c != 8'd0) ? i_src_port : 16'd0;
    end

    assign hash_nx = fnv_step(r_hash, r_key[159:152]);

    // key capture and byte-serial hash
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fam <= fam_c; r_port <= port_c; r_ah <= ah_c; r_al <= al_c;
            r_now <= i_now_ns;
            r_key <= {fam_c, 8'd0, port_c[7:0], port_c[15:8], ah_c, al_c};
            r_hash <= FNV_BASIS;
        end else if (i_cmd.hash_step) begin
            r_hash <= hash_nx;
            r_key  <= {r_key[151:0], 8'd0};
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) r_bcnt <= 5'd0;
        else if (i_cmd.hash_step) r_bcnt <= r_bcnt + 5'd1;
    end

    // slot memory; valid bits cleared by a pass after reset
    t_slot mem [TABLE_ENTRIES];
    t_slot r_rd;
    logic [AW-1:0] r_idx, r_cur, r_clr;
    logic [PW-1:0] r_pcnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx];
            r_cur <= r_idx;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clr) r_clr <= r_clr + AW'(1);
    end

    // probe index
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_step && r_bcnt == 5'd19) r_idx <= hash_nx[AW-1:0];
        else if (i_cmd.next) r_idx <= r_idx + AW'(1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) r_pcnt <= '0;
        else if (i_cmd.next) r_pcnt <= r_pcnt + PW'(1);
    end

    // probe evaluation
    logic [63:0] age;
    logic stale_c, match_c;
    always_comb begin
        age = r_now - r_rd.st;
        stale_c = age > {16'd0, i_idle};
        match_c = (r_fam != 8'd0) && (r_rd.fam == r_fam) &&
                  (!i_use_port || r_rd.port == r_port) &&
                  (r_rd.ah == r_ah) && (r_rd.al == r_al);
    end

    logic r_have_free, r_have_stale;
    logic [AW-1:0] r_new_idx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_have_free <= 1'b0; r_have_stale <= 1'b0;
        end else if (i_cmd.eval) begin
            if (!r_rd.vld) begin
                r_have_free <= 1'b1; r_new_idx <= r_cur;
            end else if (stale_c && !r_have_free) begin
                r_have_stale <= 1'b1; r_new_idx <= r_cur;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.hash_done  = (r_bcnt == 5'd20);
        o_stat.slot_free  = !r_rd.vld;
        o_stat.slot_match = r_rd.vld && match_c;
        o_stat.probe_last = (r_pcnt == PW'(PROBE_LIMIT - 1));
        o_stat.have_slot  = r_have_free || r_have_stale;
        o_stat.clr_done   = (r_clr == AW'(TABLE_ENTRIES - 1));
    end

    // refill products, registered
    logic [63:0] dt;
    logic [63:0] r_plo, r_phi;
    logic [31:0] r_dh_hi;
    logic        r_dt_nz;
    assign dt = r_now - r_rd.rt;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_plo <= dt[31:0] * i_refill;
            r_phi <= dt[63:32] * i_refill;
            r_dh_hi <= {16'd0, dt[63:48]};
            r_dt_nz <= dt != 64'd0;
        end
    end

    // token update
    logic [48:0] gain;
    logic [49:0] tsum, capv, tcap;
    logic        give;
    logic [31:0] tnew;
    always_comb begin
        if (r_phi == 64'd0) gain = {1'b0, r_plo[63:16]};
        else if (r_dh_hi != 32'd0 || r_phi >= 64'd65536) gain = {1'b0, GAIN_SAT};
        else gain = {17'd0, r_phi[15:0], 16'd0} + {1'b0, r_plo[63:16]};
        tsum = {18'd0, r_rd.tok} + {1'b0, gain};
        capv = {18'd0, i_burst, 16'd0};
        tcap = r_dt_nz ? ((tsum > capv) ? capv : tsum) : {18'd0, r_rd.tok};
        give = tcap >= 50'd65536;
        tnew = give ? 32'(tcap - 50'd65536) : tcap[31:0];
    end

    // table writes
    t_slot wslot;
    logic [AW-1:0] widx;
    always_comb begin
        if (i_cmd.clr) begin
            widx = r_clr;
            wslot = '0;
        end else if (i_cmd.upd) begin
            widx = r_cur;
            wslot = r_rd;
            wslot.tok = tnew;
            wslot.st = r_now;
            if (r_dt_nz) wslot.rt = r_now;
        end else begin
            widx = r_new_idx;
            wslot.vld = 1'b1;
            wslot.fam = r_fam; wslot.port = r_port; wslot.ah = r_ah; wslot.al = r_al;
            wslot.tok = (i_burst != 16'd0) ? {i_burst - 16'd1, 16'd0} : 32'd0;
            wslot.rt = r_now; wslot.st = r_now;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr || i_cmd.upd || i_cmd.ins) mem[widx] <= wslot;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            o_allow <= give; o_outcome <= OUT_MATCH;
        end else if (i_cmd.ins) begin
            o_allow <= 1'b1; o_outcome <= r_have_free ? OUT_FREE : OUT_STALE;
        end else if (i_cmd.load) begin
            o_allow <= 1'b0; o_outcome <= OUT_NONE;
        end
    end

`ifndef SYNTHESIS
    a_ins_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> (r_have_free || r_have_stale)) else $error("insert without slot");
    a_upd_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> r_rd.vld) else $error("update of empty slot");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.upd && i_cmd.ins)) else $error("two writes");
    a_clr_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(i_cmd.upd || i_cmd.ins)) else $error("write during clear");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/pstb_ctrl.sv @@
// controller state machine for the limiter: sequences clear, hash, probes and write
// depends on pstb_pkg
`default_nettype none
module pstb_ctrl import pstb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_HASH = 9'b0_0000_0010,
        S_RD   = 9'b0_0000_0100,
        S_EVAL = 9'b0_0000_1000,
        S_MUL  = 9'b0_0001_0000,
        S_UPD  = 9'b0_0010_0000,
        S_FIN  = 9'b0_0100_0000,
        S_OUT  = 9'b0_1000_0000,
        S_CLR  = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_oval, n_oval;

    // output register may still hold a result while a new item starts
    assign o_ready = (r_state == S_IDLE) && (!r_oval || i_ready);
    assign o_valid = r_oval;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        n_oval = r_oval && !i_ready;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.load = 1'b1; n_state = S_HASH;
            end
            S_HASH: if (i_stat.hash_done) n_state = S_RD;
                    else o_cmd.hash_step = 1'b1;
            S_RD: begin
                o_cmd.rd = 1'b1; n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.slot_free) n_state = S_FIN;
                else if (i_stat.slot_match) n_state = S_MUL;
                else if (i_stat.probe_last) n_state = S_FIN;
                else begin
                    o_cmd.next = 1'b1; n_state = S_RD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1; n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1; n_state = S_OUT;
            end
            S_FIN: begin
                o_cmd.ins = i_stat.have_slot; n_state = S_OUT;
            end
            S_OUT: if (!r_oval) begin
                n_oval = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_oval <= 1'b0;
        end else begin
            r_state <= n_state; r_oval <= n_oval;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE)) else $error("load outside idle");
    a_out_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/per_source_token_bucket_limiter.sv @@
// Per-source token bucket limiter, top level: config registers, controller, datapath.
// One result per packet. After reset a clearing pass empties the table while o_ready
// stays low. A packet then goes through byte-serial hashing with the FNV-1a step and
// prime but a non-standard offset basis (a shift-and-add multiply per key byte, then a
// check of the byte count), then table probes (registered memory read, then compare),
// up to PROBE_LIMIT probes, then the refill multiply and slot write on a match, or an
// insert if a free or stale slot was found, and last the result is raised. Packets
// are processed one at a time; the next one is taken no earlier than the edge at which
// the previous result is accepted.
// depends on pstb_pkg, pstb_ctrl, pstb_datapath
`default_nettype none
module per_source_token_bucket_limiter import pstb_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int PROBE_LIMIT   = ProbeLimitDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_now_ns,
    input  wire logic [7:0]  i_addr_family,
    input  wire logic [15:0] i_src_port,
    input  wire logic [63:0] i_address_high,
    input  wire logic [63:0] i_address_low,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_allow,
    output logic [1:0]       o_outcome,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [31:0] r_refill;
    logic [15:0] r_burst;
    logic [47:0] r_idle;
    logic        r_use_port;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refill <= 32'd4295; r_burst <= 16'd16;
            r_idle <= 48'd60000000000; r_use_port <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REFILL: r_refill <= i_cfg_data[31:0];
                REG_BURST:  r_burst <= i_cfg_data[15:0];
                REG_IDLE:   r_idle <= i_cfg_data[47:0];
                REG_PORT:   r_use_port <= i_cfg_data[0];
                default:    r_use_port <= r_use_port;
            endcase
        end
    end

    pstb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    pstb_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .PROBE_LIMIT(PROBE_LIMIT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_now_ns(i_now_ns), .i_addr_family(i_addr_family), .i_src_port(i_src_port),
        .i_address_high(i_address_high), .i_address_low(i_address_low),
        .i_refill(r_refill), .i_burst(r_burst), .i_idle(r_idle),
        .i_use_port(r_use_port), .o_allow(o_allow), .o_outcome(o_outcome)
    );
endmodule
`default_nettype wire
